FILE: sv/ps2km_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the PS/2 scancode to key matrix unit.
// Used by ps2_scancode_to_key_matrix_unit; depends on nothing.
package ps2km_pkg;

    // Matrix geometry and map store size
    localparam int unsigned ROWS       = 8;
    localparam int unsigned COLS       = 8;
    localparam int unsigned MAP_DEPTH  = 128;
    localparam int unsigned MAP_AW     = $clog2(MAP_DEPTH);
    localparam int unsigned RAM_DEPTH  = 2 * MAP_DEPTH;
    localparam int unsigned RAM_AW     = $clog2(RAM_DEPTH);
    localparam int unsigned MATRIX_W   = ROWS * COLS;
    localparam int unsigned APB_AW     = 5;

    // Scancode values with special meaning
    localparam logic [7:0] CODE_EXTENDED = 8'hE0;
    localparam logic [7:0] CODE_BREAK    = 8'hF0;
    localparam logic [7:0] CODE_F7       = 8'h83;
    localparam logic [7:0] CODE_F7_SLOT  = 8'h7F;

    // Map byte fields
    localparam int unsigned MB_SHIFT     = 7;
    localparam int unsigned MB_EXT_SHIFT = 6;
    localparam int unsigned MB_COL_LSB   = 3;
    localparam int unsigned MB_ROW_LSB   = 0;

    // Request kinds
    typedef enum logic {
        KIND_SCAN  = 1'b0,
        KIND_TABLE = 1'b1
    } t_kind;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SHIFT_ROW     = 3'd0,
        REG_SHIFT_COL     = 3'd1,
        REG_EXT_SHIFT_ROW = 3'd2,
        REG_EXT_SHIFT_COL = 3'd3,
        REG_NONE_CODE     = 3'd4
    } t_reg_idx;

    // Reset values of the configuration registers
    localparam logic [2:0] RST_SHIFT_ROW     = 3'd5;
    localparam logic [2:0] RST_SHIFT_COL     = 3'd0;
    localparam logic [2:0] RST_EXT_SHIFT_ROW = 3'd7;
    localparam logic [2:0] RST_EXT_SHIFT_COL = 3'd1;
    localparam logic [7:0] RST_NONE_CODE     = 8'd63;

    // Look-up stage control, travels with the map read
    typedef struct packed {
        logic valid;
        logic release_key;
        logic use_none;
    } t_lookup;

    // Set (release) or clear (press) one key bit in the flat matrix word
    function automatic logic [MATRIX_W-1:0] set_key(
        input logic [MATRIX_W-1:0] keys,
        input logic [2:0]          row,
        input logic [2:0]          col,
        input logic                release_key
    );
        logic [MATRIX_W-1:0] res;
        res = keys;
        res[{row, col}] = release_key;
        return res;
    endfunction

endpackage

FILE: sv/ps2km_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the scancode map store.
module ps2km_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, hold data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/ps2_scancode_to_key_matrix_unit.sv
`timescale 1ns / 1ps
// Top level of the PS/2 scancode to 8x8 key matrix unit.
// Depends on ps2km_pkg and ps2km_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request per beat:
//   a scancode byte (kind 0) or a write of one map entry (kind 1). Both
//   maps share one 256-entry RAM, addressed by {extended, index}.
//   Prefix bytes 0xE0 and 0xF0 and map writes give no result; every other
//   scancode gives one 64-bit matrix word on the output channel
//   (o_out_valid / i_out_ready), bit 8*row+column, 1 = key released.
//   The map read and the look-up stage are registered at the accepting edge;
//   the matrix and the output word are registered when that stage advances,
//   and o_out_valid rises with them.
//   Throughput: one request per cycle, set by the single map RAM port pair,
//   while no held word stalls the input; a map write followed at once by a
//   look-up of the same entry sees the new value, as the write lands first.
//   Reset: the matrix reads all ones, both prefix flags clear, the
//   configuration registers take their defaults; map contents stay unknown
//   until written. No clearing pass is run.
//   Stall: a held output word keeps the look-up stage; while that stage is
//   full and blocked, o_in_ready drops. Configuration is written over APB.
module ps2_scancode_to_key_matrix_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_kind,
    input  logic [7:0]                         i_scan_byte,
    input  logic                               i_entry_extended,
    input  logic [6:0]                         i_entry_index,
    input  logic [7:0]                         i_entry_value,
    // Output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ps2km_pkg::MATRIX_W-1:0]     o_matrix_bits,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ps2km_pkg::APB_AW-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // Configuration registers
    logic [2:0] r_shift_row;
    logic [2:0] r_shift_col;
    logic [2:0] r_ext_shift_row;
    logic [2:0] r_ext_shift_col;
    logic [7:0] r_none_code;

    // Prefix flags and look-up stage
    logic                r_ext_pend;
    logic                r_brk_pend;
    ps2km_pkg::t_lookup  r_lookup;
    ps2km_pkg::t_lookup  n_lookup;

    // Matrix state and output register
    logic [ps2km_pkg::MATRIX_W-1:0] r_keys;
    logic [ps2km_pkg::MATRIX_W-1:0] n_keys;
    logic [ps2km_pkg::MATRIX_W-1:0] r_out_data;
    logic                           r_out_valid;

    // Handshake and decode
    logic                           in_acc;
    logic                           is_table;
    logic                           is_ext_prefix;
    logic                           is_brk_prefix;
    logic                           is_lookup;
    logic                           lookup_adv;
    logic                           cfg_wr;
    ps2km_pkg::t_reg_idx            cfg_idx;
    logic [7:0]                     code_mapped;

    // Map RAM ports
    logic                               ram_we;
    logic [ps2km_pkg::RAM_AW-1:0]       ram_waddr;
    logic                               ram_re;
    logic [ps2km_pkg::RAM_AW-1:0]       ram_raddr;
    logic [7:0]                         ram_rdata;
    logic [7:0]                         map_byte;

    // Configuration write and read back
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = ps2km_pkg::t_reg_idx'(paddr[ps2km_pkg::APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_row     <= ps2km_pkg::RST_SHIFT_ROW;
            r_shift_col     <= ps2km_pkg::RST_SHIFT_COL;
            r_ext_shift_row <= ps2km_pkg::RST_EXT_SHIFT_ROW;
            r_ext_shift_col <= ps2km_pkg::RST_EXT_SHIFT_COL;
            r_none_code     <= ps2km_pkg::RST_NONE_CODE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ps2km_pkg::REG_SHIFT_ROW:     r_shift_row     <= pwdata[2:0];
                ps2km_pkg::REG_SHIFT_COL:     r_shift_col     <= pwdata[2:0];
                ps2km_pkg::REG_EXT_SHIFT_ROW: r_ext_shift_row <= pwdata[2:0];
                ps2km_pkg::REG_EXT_SHIFT_COL: r_ext_shift_col <= pwdata[2:0];
                ps2km_pkg::REG_NONE_CODE:     r_none_code     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            ps2km_pkg::REG_SHIFT_ROW:     prdata = {29'd0, r_shift_row};
            ps2km_pkg::REG_SHIFT_COL:     prdata = {29'd0, r_shift_col};
            ps2km_pkg::REG_EXT_SHIFT_ROW: prdata = {29'd0, r_ext_shift_row};
            ps2km_pkg::REG_EXT_SHIFT_COL: prdata = {29'd0, r_ext_shift_col};
            ps2km_pkg::REG_NONE_CODE:     prdata = {24'd0, r_none_code};
            default:                      prdata = 32'd0;
        endcase
    end

    // Advance the look-up stage whenever the output register frees up
    assign lookup_adv = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_lookup.valid || lookup_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // Decode the accepted request
    assign is_table      = (ps2km_pkg::t_kind'(i_kind) == ps2km_pkg::KIND_TABLE);
    assign is_ext_prefix = !is_table && (i_scan_byte == ps2km_pkg::CODE_EXTENDED);
    assign is_brk_prefix = !is_table && (i_scan_byte == ps2km_pkg::CODE_BREAK);
    assign is_lookup     = !is_table && !is_ext_prefix && !is_brk_prefix;

    // Remap the F7 code into the last normal slot when no extended prefix is pending
    assign code_mapped = (!r_ext_pend && (i_scan_byte == ps2km_pkg::CODE_F7))
                         ? ps2km_pkg::CODE_F7_SLOT : i_scan_byte;

    // Map RAM: writes from table requests, reads from looked-up bytes
    assign ram_we    = in_acc && is_table;
    assign ram_waddr = {i_entry_extended, i_entry_index};
    assign ram_re    = in_acc && is_lookup;
    assign ram_raddr = {r_ext_pend, code_mapped[ps2km_pkg::MAP_AW-1:0]};

    ps2km_ram #(
        .WIDTH (8),
        .DEPTH (ps2km_pkg::RAM_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_entry_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Prefix flags: set by prefixes, dropped by any looked-up byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_pend <= 1'b0;
            r_brk_pend <= 1'b0;
        end else if (in_acc) begin
            if (is_ext_prefix) begin
                r_ext_pend <= 1'b1;
            end else if (is_brk_prefix) begin
                r_brk_pend <= 1'b1;
            end else if (is_lookup) begin
                r_ext_pend <= 1'b0;
                r_brk_pend <= 1'b0;
            end
        end
    end

    // Load the look-up stage alongside the map read
    always_comb begin
        n_lookup = r_lookup;
        if (lookup_adv) begin
            n_lookup.valid = 1'b0;
        end
        if (in_acc && is_lookup) begin
            n_lookup.valid       = 1'b1;
            n_lookup.release_key = r_brk_pend;
            n_lookup.use_none    = code_mapped[ps2km_pkg::MAP_AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookup <= '0;
        end else begin
            r_lookup <= n_lookup;
        end
    end

    // Apply key, shift and extended shift to the matrix
    assign map_byte = r_lookup.use_none ? r_none_code : ram_rdata;

    always_comb begin
        n_keys = ps2km_pkg::set_key(r_keys,
                                    map_byte[ps2km_pkg::MB_ROW_LSB +: 3],
                                    map_byte[ps2km_pkg::MB_COL_LSB +: 3],
                                    r_lookup.release_key);
        if (map_byte[ps2km_pkg::MB_SHIFT]) begin
            n_keys = ps2km_pkg::set_key(n_keys, r_shift_row, r_shift_col,
                                        r_lookup.release_key);
        end
        if (map_byte[ps2km_pkg::MB_EXT_SHIFT]) begin
            n_keys = ps2km_pkg::set_key(n_keys, r_ext_shift_row, r_ext_shift_col,
                                        r_lookup.release_key);
        end
    end

    // Commit the matrix and hand the word to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_lookup.valid && lookup_adv) begin
                r_keys      <= n_keys;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_lookup.valid && lookup_adv) begin
            r_out_data <= n_keys;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_matrix_bits = r_out_data;

`ifndef SYNTHESIS
    // Input is refused only when the look-up stage is blocked by a held word
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_lookup.valid && r_out_valid && !i_out_ready))
        else $error("input refused without a blocked look-up stage");

    // A looked-up byte drops both prefix flags
    a_lookup_drops_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_lookup) |=> (!r_ext_pend && !r_brk_pend))
        else $error("prefix flag survived a looked-up byte");

    // A blocked look-up stage keeps its request and the map data
    a_lookup_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lookup.valid && !lookup_adv) |=> (r_lookup.valid && $stable(ram_rdata)))
        else $error("blocked look-up lost its request or map data");

    // The output word mirrors the committed matrix while it is valid
    a_out_matches_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data == r_keys))
        else $error("output word differs from matrix state");

    // Table writes and prefixes never give a result
    a_no_result_for_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_lookup && !r_lookup.valid) |=> !r_lookup.valid)
        else $error("silent request entered the look-up stage");
`endif

endmodule

FILE: tb/sv/ps2_scancode_to_key_matrix_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ps2_scancode_to_key_matrix_unit: scancode and map-write
// requests against a built-in key matrix predictor, under random stalls on both sides.
// Depends on ps2km_pkg and the unit itself; reads no files.
module ps2_scancode_to_key_matrix_unit_tb;

    localparam int PHASE_ITEMS = 238;
    localparam int STALL_LIMIT = 4000;

    // Map byte layout: shift, extended shift, column, row
    typedef struct packed {
        logic       shift;
        logic       ext_shift;
        logic [2:0] col;
        logic [2:0] row;
    } t_map_byte;

    // One row of the directed stimulus
    typedef struct packed {
        ps2km_pkg::t_kind kind;
        logic [7:0]       scan;
        logic             ext;
        logic [6:0]       idx;
        logic [7:0]       val;
        logic             typed;
        logic [63:0]      word;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic                           i_kind = 1'b0;
    logic [7:0]                     i_scan_byte = 8'h00;
    logic                           i_entry_extended = 1'b0;
    logic [6:0]                     i_entry_index = 7'h00;
    logic [7:0]                     i_entry_value = 8'h00;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [ps2km_pkg::MATRIX_W-1:0] o_matrix_bits;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [ps2km_pkg::APB_AW-1:0]   paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    ps2_scancode_to_key_matrix_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_scan_byte      (i_scan_byte),
        .i_entry_extended (i_entry_extended),
        .i_entry_index    (i_entry_index),
        .i_entry_value    (i_entry_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_matrix_bits    (o_matrix_bits),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Predictor state and its copy of the configuration
    logic [63:0] key_state = '1;
    logic        ext_pend = 1'b0;
    logic        brk_pend = 1'b0;
    logic [7:0]  norm_map [ps2km_pkg::MAP_DEPTH];
    logic [7:0]  ext_map [ps2km_pkg::MAP_DEPTH];
    logic [2:0]  cfg_shift_row = ps2km_pkg::RST_SHIFT_ROW;
    logic [2:0]  cfg_shift_col = ps2km_pkg::RST_SHIFT_COL;
    logic [2:0]  cfg_ext_row = ps2km_pkg::RST_EXT_SHIFT_ROW;
    logic [2:0]  cfg_ext_col = ps2km_pkg::RST_EXT_SHIFT_COL;
    logic [7:0]  cfg_none = ps2km_pkg::RST_NONE_CODE;

    // Stimulus-side view: prefix state and which map entries hold data
    bit          gen_ext_pend = 1'b0;
    bit          gen_norm_wr [ps2km_pkg::MAP_DEPTH];
    bit          gen_ext_wr [ps2km_pkg::MAP_DEPTH];

    logic [63:0] matrix_words_due [$];
    t_stim_row   stim_rows [$];
    bit          drv_typed_ok = 1'b0;
    logic [63:0] drv_typed_word = '0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          req_sent = 0;
    int          err_count = 0;
    int          words_checked = 0;
    int          map_writes = 0;
    int          prefixes = 0;
    int          idle_cycles = 0;

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Print one mismatch line and count it
    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Apply one accepted request to the predictor; return 1 with the matrix word
    // when the request produces one
    function automatic bit predict_matrix(input ps2km_pkg::t_kind kind,
                                          input logic [7:0] scan,
                                          input logic ext, input logic [6:0] idx,
                                          input logic [7:0] val, output logic [63:0] word);
        t_map_byte  mb;
        logic [7:0] code;
        logic       rel;
        word = key_state;
        if (kind == ps2km_pkg::KIND_TABLE) begin
            if (ext) ext_map[idx] = val;
            else norm_map[idx] = val;
            return 1'b0;
        end
        if (scan == ps2km_pkg::CODE_EXTENDED) begin
            ext_pend = 1'b1;
            return 1'b0;
        end
        if (scan == ps2km_pkg::CODE_BREAK) begin
            brk_pend = 1'b1;
            return 1'b0;
        end
        code = scan;
        if (ext_pend) begin
            mb = code[7] ? cfg_none : ext_map[code[6:0]];
        end else begin
            if (code == ps2km_pkg::CODE_F7) code = ps2km_pkg::CODE_F7_SLOT;
            mb = code[7] ? cfg_none : norm_map[code[6:0]];
        end
        rel = brk_pend;
        ext_pend = 1'b0;
        brk_pend = 1'b0;
        // Key first, then shift, then extended shift, all the same way
        key_state[{mb.row, mb.col}] = rel;
        if (mb.shift) key_state[{cfg_shift_row, cfg_shift_col}] = rel;
        if (mb.ext_shift) key_state[{cfg_ext_row, cfg_ext_col}] = rel;
        word = key_state;
        return 1'b1;
    endfunction

    // Output stall pattern
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Check results, predict accepted requests and guard against a hang
    always @(posedge i_clk) begin
        logic [63:0] want;
        logic [63:0] word;
        bit          has_word;
        idle_cycles++;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                idle_cycles = 0;
                if (matrix_words_due.size() == 0) begin
                    flag_mismatch("matrix word with nothing pending", o_matrix_bits, '0);
                end else begin
                    want = matrix_words_due.pop_front();
                    if (o_matrix_bits !== want) flag_mismatch("matrix_bits", o_matrix_bits, want);
                    words_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                idle_cycles = 0;
                if (i_kind == ps2km_pkg::KIND_TABLE) map_writes++;
                else if (i_scan_byte == ps2km_pkg::CODE_EXTENDED ||
                         i_scan_byte == ps2km_pkg::CODE_BREAK) prefixes++;
                has_word = predict_matrix(ps2km_pkg::t_kind'(i_kind), i_scan_byte,
                                          i_entry_extended, i_entry_index, i_entry_value,
                                          word);
                if (has_word) matrix_words_due.push_back(drv_typed_ok ? drv_typed_word : word);
            end
            if (psel && penable && pready) idle_cycles = 0;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles, %0d words outstanding",
                     STALL_LIMIT, matrix_words_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one request and hold it until accepted
    task automatic send_req(input ps2km_pkg::t_kind kind, input logic [7:0] scan,
                            input logic ext, input logic [6:0] idx, input logic [7:0] val,
                            input bit typed_ok, input logic [63:0] typed_word);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= kind;
        i_scan_byte      <= scan;
        i_entry_extended <= ext;
        i_entry_index    <= idx;
        i_entry_value    <= val;
        drv_typed_ok     = typed_ok;
        drv_typed_word   = typed_word;
        do @(posedge i_clk); while (!o_in_ready);
        req_sent++;
    endtask

    // Write one map entry; the unused scancode field carries noise
    task automatic send_entry(input logic ext, input logic [6:0] idx, input logic [7:0] val);
        if (ext) gen_ext_wr[idx] = 1'b1;
        else gen_norm_wr[idx] = 1'b1;
        send_req(ps2km_pkg::KIND_TABLE, 8'($urandom_range(0, 255)), ext, idx, val,
                 1'b0, '0);
    endtask

    // Send one scancode byte; load the entry it reads first if it holds no data yet
    task automatic send_scan(input logic [7:0] b, input bit typed_ok,
                             input logic [63:0] typed_word);
        logic [7:0] c;
        if (b == ps2km_pkg::CODE_EXTENDED) begin
            gen_ext_pend = 1'b1;
        end else if (b != ps2km_pkg::CODE_BREAK) begin
            c = (!gen_ext_pend && b == ps2km_pkg::CODE_F7) ? ps2km_pkg::CODE_F7_SLOT : b;
            if (!c[7] && !(gen_ext_pend ? gen_ext_wr[c[6:0]] : gen_norm_wr[c[6:0]]))
                send_entry(gen_ext_pend, c[6:0], 8'($urandom_range(0, 255)));
            gen_ext_pend = 1'b0;
        end
        send_req(ps2km_pkg::KIND_SCAN, b, 1'($urandom_range(0, 1)),
                 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                 typed_ok, typed_word);
    endtask

    // Random code: mostly mapped codes, some remapped ones and some beyond the maps
    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72) return 8'($urandom_range(0, 127));
        if (r < 80) return ps2km_pkg::CODE_F7;
        return 8'($urandom_range(128, 255));
    endfunction

    // Drop valid, then hold until every expected word is in, plus a settle time
    task automatic drain_results(input int settle);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (matrix_words_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Read one register back and compare
    task automatic check_reg(input ps2km_pkg::t_reg_idx idx, input logic [31:0] want);
        logic [31:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) flag_mismatch($sformatf("read of register %s", idx.name()),
                                        64'(got), 64'(want));
    endtask

    // Write one register, update the predictor copy, then read it back
    task automatic cfg_write(input ps2km_pkg::t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        unique case (idx)
            ps2km_pkg::REG_SHIFT_ROW:     cfg_shift_row = value[2:0];
            ps2km_pkg::REG_SHIFT_COL:     cfg_shift_col = value[2:0];
            ps2km_pkg::REG_EXT_SHIFT_ROW: cfg_ext_row = value[2:0];
            ps2km_pkg::REG_EXT_SHIFT_COL: cfg_ext_col = value[2:0];
            ps2km_pkg::REG_NONE_CODE:     cfg_none = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_reg(idx, value);
    endtask

    // Append one directed row
    task automatic add_row(input ps2km_pkg::t_kind kind, input logic [7:0] scan,
                           input logic ext, input logic [6:0] idx, input logic [7:0] val,
                           input logic typed, input logic [63:0] word);
        t_stim_row r;
        r.kind = kind; r.scan = scan; r.ext = ext; r.idx = idx; r.val = val;
        r.typed = typed; r.word = word;
        stim_rows.push_back(r);
    endtask

    // Main sequence
    initial begin
        int         ph;
        int         sel;
        int         phase_start;
        bit         drained;
        logic [2:0] sr, sc, er, ec;
        logic [7:0] nc;
        t_stim_row  r;

        for (int k = 0; k < ps2km_pkg::MAP_DEPTH; k++) begin
            gen_norm_wr[k] = 1'b0;
            gen_ext_wr[k]  = 1'b0;
        end

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers come up at their defaults
        check_reg(ps2km_pkg::REG_SHIFT_ROW, 32'(ps2km_pkg::RST_SHIFT_ROW));
        check_reg(ps2km_pkg::REG_SHIFT_COL, 32'(ps2km_pkg::RST_SHIFT_COL));
        check_reg(ps2km_pkg::REG_EXT_SHIFT_ROW, 32'(ps2km_pkg::RST_EXT_SHIFT_ROW));
        check_reg(ps2km_pkg::REG_EXT_SHIFT_COL, 32'(ps2km_pkg::RST_EXT_SHIFT_COL));
        check_reg(ps2km_pkg::REG_NONE_CODE, 32'(ps2km_pkg::RST_NONE_CODE));

        // Directed part, default registers: make and break of a plain key, a key with
        // both shifts, the remapped code, extended forms and both prefix orders,
        // codes beyond the maps with and without the extended prefix
        add_row(ps2km_pkg::KIND_TABLE, 8'h00, 1'b0, 7'h1C, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  8'h1C, 1'b0, 7'h00, 8'h00, 1'b1,
                64'hFFFF_FFFF_FFFF_FFFE);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_BREAK, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  8'h1C, 1'b0, 7'h00, 8'h00, 1'b1,
                64'hFFFF_FFFF_FFFF_FFFF);
        add_row(ps2km_pkg::KIND_TABLE, 8'hFF, 1'b0, 7'h00, 8'hFF, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  8'h00, 1'b1, 7'h7F, 8'hFF, 1'b1,
                64'h7DFF_FEFF_FFFF_FFFF);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_BREAK, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  8'h00, 1'b0, 7'h00, 8'h00, 1'b1,
                64'hFFFF_FFFF_FFFF_FFFF);
        add_row(ps2km_pkg::KIND_TABLE, 8'h00, 1'b0, 7'h7F, 8'h3F, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_F7, 1'b0, 7'h00, 8'h00, 1'b1,
                64'h7FFF_FFFF_FFFF_FFFF);
        add_row(ps2km_pkg::KIND_TABLE, 8'h00, 1'b1, 7'h7F, 8'h80, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_EXTENDED, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  8'h7F, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_EXTENDED, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_BREAK, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  8'h7F, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_BREAK, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_EXTENDED, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  8'h7F, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  8'hFF, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_EXTENDED, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_F7, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_EXTENDED, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  ps2km_pkg::CODE_EXTENDED, 1'b0, 7'h00, 8'h00, 1'b0, '0);
        add_row(ps2km_pkg::KIND_SCAN,  8'h80, 1'b0, 7'h00, 8'h00, 1'b0, '0);

        snd_idle_pct = 21;
        rcv_idle_pct = 87;
        foreach (stim_rows[k]) begin
            r = stim_rows[k];
            if (r.kind == ps2km_pkg::KIND_TABLE) send_entry(r.ext, r.idx, r.val);
            else send_scan(r.scan, r.typed, r.word);
        end
        drain_results(4);

        // Random part: six register settings, the stall pattern changes every two
        for (ph = 0; ph < 6; ph++) begin
            unique case (ph / 2)
                0: begin snd_idle_pct = 21; rcv_idle_pct = 87; end
                1: begin snd_idle_pct = 87; rcv_idle_pct = 21; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            unique case (ph)
                0: begin sr = 3'd0; sc = 3'd0; er = 3'd0; ec = 3'd0; nc = 8'h00; end
                1: begin sr = 3'd7; sc = 3'd7; er = 3'd7; ec = 3'd7; nc = 8'hFF; end
                3: begin sr = 3'd3; sc = 3'd4; er = 3'd1; ec = 3'd6; nc = 8'h80; end
                default: begin
                    sr = 3'($urandom_range(0, 7));
                    sc = 3'($urandom_range(0, 7));
                    er = 3'($urandom_range(0, 7));
                    ec = 3'($urandom_range(0, 7));
                    nc = 8'($urandom_range(0, 255));
                end
            endcase
            cfg_write(ps2km_pkg::REG_SHIFT_ROW, 32'(sr));
            cfg_write(ps2km_pkg::REG_SHIFT_COL, 32'(sc));
            cfg_write(ps2km_pkg::REG_EXT_SHIFT_ROW, 32'(er));
            cfg_write(ps2km_pkg::REG_EXT_SHIFT_COL, 32'(ec));
            cfg_write(ps2km_pkg::REG_NONE_CODE, 32'(nc));

            phase_start = req_sent;
            drained = 1'b0;
            while (req_sent - phase_start < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    send_entry(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                               8'($urandom_range(0, 255)));
                end else if (sel < 35) begin
                    send_scan(pick_code(), 1'b0, '0);
                end else if (sel < 55) begin
                    send_scan(ps2km_pkg::CODE_BREAK, 1'b0, '0);
                    send_scan(pick_code(), 1'b0, '0);
                end else if (sel < 70) begin
                    send_scan(ps2km_pkg::CODE_EXTENDED, 1'b0, '0);
                    send_scan(pick_code(), 1'b0, '0);
                end else if (sel < 82) begin
                    send_scan(ps2km_pkg::CODE_EXTENDED, 1'b0, '0);
                    send_scan(ps2km_pkg::CODE_BREAK, 1'b0, '0);
                    send_scan(pick_code(), 1'b0, '0);
                end else begin
                    // Noise: stray prefixes and arbitrary bytes
                    sel = $urandom_range(0, 99);
                    if (sel < 15) send_scan(ps2km_pkg::CODE_EXTENDED, 1'b0, '0);
                    else if (sel < 30) send_scan(ps2km_pkg::CODE_BREAK, 1'b0, '0);
                    else send_scan(8'($urandom_range(0, 255)), 1'b0, '0);
                end
                // Hold the sender until the pipeline is empty, once mid-phase and
                // now and then at random
                if (!drained && req_sent - phase_start >= PHASE_ITEMS / 2) begin
                    drain_results(0);
                    drained = 1'b1;
                end else if ($urandom_range(0, 199) == 0) begin
                    drain_results(0);
                end
            end
            drain_results(4);
        end

        drain_results(8);
        $display("Run covered %0d requests: %0d map writes, %0d prefix bytes, %0d words checked",
                 req_sent, map_writes, prefixes, words_checked);
        $display("Six register settings including both extremes, stalls on each side in turn");
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
